[rtl/core/pdoc_pkg.sv]
// Shared types, constants and alpha lookup tables for the pixel diff
// overlay compositor. No dependencies.
`default_nettype none

package pdoc_pkg;

  localparam int FRAC = 24;          // fraction bits of alpha and weights
  localparam int FXW  = FRAC + 1;    // fixed-point value up to 1.0
  localparam int OAW  = FXW + 1;     // blended alpha, with rounding headroom
  localparam int DVW  = OAW + 1;     // doubled divisor
  localparam int QW   = FXW;         // quotient bits of a weight
  localparam int NUMW = FXW + FRAC + 2;
  localparam int OVER_LAT = QW + 5;  // register stages through one blend unit

  localparam longint unsigned LO_DIV = 1275;  // opacity 0.2
  localparam longint unsigned HI_DIV = 255;   // opacity 1.0

  localparam logic [FXW-1:0] FX_ONE = {1'b1, {FRAC{1'b0}}};

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_ADD  = 2'd1,
    CLS_DEL  = 2'd2,
    CLS_MOD  = 2'd3
  } diff_class_t;

  typedef enum logic [1:0] {
    REG_ADD_COLOR = 2'd0,
    REG_DEL_COLOR = 2'd1,
    REG_MOD_COLOR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  a_red;
    logic [7:0]  a_green;
    logic [7:0]  a_blue;
    logic [7:0]  a_alpha;
    logic [7:0]  b_red;
    logic [7:0]  b_green;
    logic [7:0]  b_blue;
    logic [7:0]  b_alpha;
    logic        masked;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  overlay_red;
    logic [7:0]  overlay_green;
    logic [7:0]  overlay_blue;
    logic [7:0]  overlay_alpha;
    diff_class_t diff_class;
    logic [11:0] out_x;
    logic [11:0] out_y;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef logic [255:0][FXW-1:0] fx_tbl_t;
  typedef logic [255:0][7:0]     byte_tbl_t;

  // rnd(i * 1.0 / 1275)
  function automatic fx_tbl_t gen_sa_lo();
    fx_tbl_t tbl;
    longint unsigned n;
    for (int i = 0; i < 256; i++) begin
      n = (64'(i) << (FRAC + 1)) + LO_DIV;
      tbl[i] = FXW'(n / (2 * LO_DIV));
    end
    return tbl;
  endfunction

  // rnd(i * 1.0 / 255)
  function automatic fx_tbl_t gen_sa_hi();
    fx_tbl_t tbl;
    longint unsigned n;
    for (int i = 0; i < 256; i++) begin
      n = (64'(i) << (FRAC + 1)) + HI_DIV;
      tbl[i] = FXW'(n / (2 * HI_DIV));
    end
    return tbl;
  endfunction

  localparam fx_tbl_t SA_LO_TBL = gen_sa_lo();
  localparam fx_tbl_t SA_HI_TBL = gen_sa_hi();

  // alpha after blending over a transparent pixel at opacity 0.2
  function automatic byte_tbl_t gen_alpha1();
    byte_tbl_t tbl;
    longint unsigned n;
    for (int i = 0; i < 256; i++) begin
      n = (64'(SA_LO_TBL[i]) * 64'd255 + (64'd1 << (FRAC - 1))) >> FRAC;
      tbl[i] = (n > 64'd255) ? 8'd255 : 8'(n);
    end
    return tbl;
  endfunction

  localparam byte_tbl_t ALPHA1_TBL = gen_alpha1();

endpackage

`default_nettype wire

[rtl/core/pdoc_over_unit.sv]
// Pipelined Porter-Duff over of one source color onto one destination pixel.
// Uses pdoc_pkg; the pipeline advances only while en is high.
`default_nettype none

module pdoc_over_unit (
  input  logic                     clk,
  input  logic                     en,
  input  pdoc_pkg::rgba_t          i_dest,
  input  pdoc_pkg::rgb_t           i_src,
  input  logic [pdoc_pkg::FXW-1:0] i_sa,
  output pdoc_pkg::rgba_t          o_pix
);

  localparam int FRAC = pdoc_pkg::FRAC;
  localparam int FXW  = pdoc_pkg::FXW;
  localparam int OAW  = pdoc_pkg::OAW;
  localparam int DVW  = pdoc_pkg::DVW;
  localparam int QW   = pdoc_pkg::QW;
  localparam int NUMW = pdoc_pkg::NUMW;
  localparam int PW   = FXW + 8;   // byte times weight
  localparam int SW   = PW + 1;

  typedef struct packed {
    logic [DVW-1:0]  dv;
    logic [OAW-1:0]  oa;
    pdoc_pkg::rgba_t dest;
    pdoc_pkg::rgb_t  src;
    logic            skip;
    logic [QW-1:0]   lo_s;
    logic [QW-1:0]   lo_d;
  } div_car_t;

  function automatic logic [DVW:0] div_step(input logic [DVW-1:0] rem, input logic nb,
                                            input logic [DVW-1:0] dv);
    logic [DVW:0] trial;
    logic [DVW:0] diff;
    trial = {rem, nb};
    diff  = trial - {1'b0, dv};
    if (trial >= {1'b0, dv}) begin
      div_step = {diff[DVW-1:0], 1'b1};
    end else begin
      div_step = {trial[DVW-1:0], 1'b0};
    end
  endfunction

  function automatic logic [7:0] round_sat(input logic [SW-1:0] s);
    logic [SW-1:0] v;
    v = (s + (SW'(1) << (FRAC - 1))) >> FRAC;
    round_sat = (v > SW'(255)) ? 8'd255 : v[7:0];
  endfunction

  // stage A: destination alpha to fixed point
  pdoc_pkg::rgba_t a_dest_r;
  pdoc_pkg::rgb_t  a_src_r;
  logic [FXW-1:0]  a_sa_r, a_da_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_dest_r <= i_dest;
      a_src_r  <= i_src;
      a_sa_r   <= i_sa;
      a_da_r   <= pdoc_pkg::SA_HI_TBL[i_dest.alpha];
    end
  end

  // stage B: t = da * (1 - sa)
  logic [2*FXW-1:0] tprod;
  logic [FXW-1:0]   b_t_nxt;
  pdoc_pkg::rgba_t  b_dest_r;
  pdoc_pkg::rgb_t   b_src_r;
  logic [FXW-1:0]   b_sa_r, b_t_r;

  assign tprod   = a_da_r * (pdoc_pkg::FX_ONE - a_sa_r);
  assign b_t_nxt = FXW'((tprod + ((2*FXW)'(1) << (FRAC - 1))) >> FRAC);

  always_ff @(posedge clk) begin
    if (en) begin
      b_dest_r <= a_dest_r;
      b_src_r  <= a_src_r;
      b_sa_r   <= a_sa_r;
      b_t_r    <= b_t_nxt;
    end
  end

  // stage C: out alpha, weight dividends; index 0 of the divider arrays
  logic [OAW-1:0]  oa_nxt;
  logic [NUMW-1:0] num_s, num_d;
  div_car_t        car_r [QW+1];
  logic [DVW-1:0]  rs_r  [QW+1];
  logic [DVW-1:0]  rd_r  [QW+1];
  logic [QW-1:0]   qs_r  [QW+1];
  logic [QW-1:0]   qd_r  [QW+1];
  logic [DVW:0]    st_s  [QW];
  logic [DVW:0]    st_d  [QW];

  assign oa_nxt = OAW'(b_sa_r) + OAW'(b_t_r);
  assign num_s  = (NUMW'(b_sa_r) << (FRAC + 1)) + NUMW'(oa_nxt);
  assign num_d  = (NUMW'(b_t_r) << (FRAC + 1)) + NUMW'(oa_nxt);

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      st_s[k] = div_step(rs_r[k], car_r[k].lo_s[QW-1-k], car_r[k].dv);
      st_d[k] = div_step(rd_r[k], car_r[k].lo_d[QW-1-k], car_r[k].dv);
    end
  end

  // restoring division, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      car_r[0].dv   <= {oa_nxt, 1'b0};
      car_r[0].oa   <= oa_nxt;
      car_r[0].dest <= b_dest_r;
      car_r[0].src  <= b_src_r;
      car_r[0].skip <= (b_sa_r == '0);
      car_r[0].lo_s <= num_s[QW-1:0];
      car_r[0].lo_d <= num_d[QW-1:0];
      rs_r[0]       <= DVW'(num_s[NUMW-1:QW]);
      rd_r[0]       <= DVW'(num_d[NUMW-1:QW]);
      qs_r[0]       <= '0;
      qd_r[0]       <= '0;
      for (int k = 0; k < QW; k++) begin
        car_r[k+1] <= car_r[k];
        rs_r[k+1]  <= st_s[k][DVW:1];
        rd_r[k+1]  <= st_d[k][DVW:1];
        qs_r[k+1]  <= {qs_r[k][QW-2:0], st_s[k][0]};
        qd_r[k+1]  <= {qd_r[k][QW-2:0], st_d[k][0]};
      end
    end
  end

  // stage P: weighted products
  logic [PW-1:0]   p_sr_r, p_sg_r, p_sb_r, p_dr_r, p_dg_r, p_db_r;
  logic [SW-1:0]   p_a_r;
  pdoc_pkg::rgba_t p_dest_r;
  logic            p_skip_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_sr_r   <= car_r[QW].src.red    * qs_r[QW];
      p_sg_r   <= car_r[QW].src.green  * qs_r[QW];
      p_sb_r   <= car_r[QW].src.blue   * qs_r[QW];
      p_dr_r   <= car_r[QW].dest.red   * qd_r[QW];
      p_dg_r   <= car_r[QW].dest.green * qd_r[QW];
      p_db_r   <= car_r[QW].dest.blue  * qd_r[QW];
      p_a_r    <= SW'(car_r[QW].oa) * SW'(255);
      p_dest_r <= car_r[QW].dest;
      p_skip_r <= car_r[QW].skip;
    end
  end

  // stage F: round, saturate; zero source alpha leaves the pixel as is
  pdoc_pkg::rgba_t blend;

  always_comb begin
    blend.red   = round_sat(SW'(p_sr_r) + SW'(p_dr_r));
    blend.green = round_sat(SW'(p_sg_r) + SW'(p_dg_r));
    blend.blue  = round_sat(SW'(p_sb_r) + SW'(p_db_r));
    blend.alpha = round_sat(p_a_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_pix <= p_skip_r ? p_dest_r : blend;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pixel_diff_overlay_compositor_core.sv]
// Pixel diff overlay compositor top level: input register, classification,
// two pdoc_over_unit blend pipelines and the output register. Uses pdoc_pkg.
//
//   channel | direction | handshake              | word
//   in_     | in        | in_valid / in_stall    | pdoc_pkg::pix_in_t
//   out_    | out       | out_valid / out_stall  | pdoc_pkg::pix_out_t
//   cfg_    | in        | cfg_wr_en, cfg_index   | 32-bit palette color
//
// One word per cycle while no output word waits under out_stall.
// Synchronous active-low reset clears valid bits and palette registers.
// The whole pipeline holds while the output word waits under out_stall;
// in_stall follows it.
`default_nettype none

module pixel_diff_overlay_compositor_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pdoc_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pdoc_pkg::pix_out_t out_data,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int LAT = pdoc_pkg::OVER_LAT;
  localparam int FXW = pdoc_pkg::FXW;

  typedef struct packed {
    pdoc_pkg::diff_class_t cls;
    pdoc_pkg::rgb_t        pal;
    logic [FXW-1:0]        pal_sa;
    logic [11:0]           x;
    logic [11:0]           y;
  } side1_t;

  typedef struct packed {
    pdoc_pkg::diff_class_t cls;
    logic [11:0]           x;
    logic [11:0]           y;
  } side2_t;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // palette registers
  logic [31:0] add_color_r, del_color_r, mod_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_color_r <= '0;
      del_color_r <= '0;
      mod_color_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pdoc_pkg::REG_ADD_COLOR: add_color_r <= cfg_wdata;
        pdoc_pkg::REG_DEL_COLOR: del_color_r <= cfg_wdata;
        pdoc_pkg::REG_MOD_COLOR: mod_color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 0: input register
  pdoc_pkg::pix_in_t in_r;
  logic              v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_data;
    end
  end

  // stage 1: first blend over transparent is a table lookup; classify
  pdoc_pkg::diff_class_t cls_nxt;
  logic [31:0]           color;
  logic                  same, both_clear;
  pdoc_pkg::rgba_t       dest_nxt;

  always_comb begin
    same       = (in_r.a_red == in_r.b_red) && (in_r.a_green == in_r.b_green) &&
                 (in_r.a_blue == in_r.b_blue) && (in_r.a_alpha == in_r.b_alpha);
    both_clear = (in_r.a_alpha == 8'd0) && (in_r.b_alpha == 8'd0);
    priority if (in_r.masked || same || both_clear) begin
      cls_nxt = pdoc_pkg::CLS_NONE;
      color   = '0;
    end else if (in_r.a_alpha == 8'd0) begin
      cls_nxt = pdoc_pkg::CLS_ADD;
      color   = add_color_r;
    end else if (in_r.b_alpha == 8'd0) begin
      cls_nxt = pdoc_pkg::CLS_DEL;
      color   = del_color_r;
    end else begin
      cls_nxt = pdoc_pkg::CLS_MOD;
      color   = mod_color_r;
    end
    if (in_r.a_alpha != 8'd0) begin
      dest_nxt.red   = in_r.a_red;
      dest_nxt.green = in_r.a_green;
      dest_nxt.blue  = in_r.a_blue;
    end else begin
      dest_nxt.red   = '0;
      dest_nxt.green = '0;
      dest_nxt.blue  = '0;
    end
    dest_nxt.alpha = pdoc_pkg::ALPHA1_TBL[in_r.a_alpha];
  end

  pdoc_pkg::rgba_t s1_dest_r;
  pdoc_pkg::rgb_t  s1_src_r;
  logic [FXW-1:0]  s1_sa_r;
  side1_t          s1_side_r;
  logic            v1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dest_r        <= dest_nxt;
      s1_src_r.red     <= in_r.b_red;
      s1_src_r.green   <= in_r.b_green;
      s1_src_r.blue    <= in_r.b_blue;
      s1_sa_r          <= pdoc_pkg::SA_LO_TBL[in_r.b_alpha];
      s1_side_r.cls    <= cls_nxt;
      s1_side_r.pal    <= color[31:8];
      s1_side_r.pal_sa <= (cls_nxt == pdoc_pkg::CLS_NONE) ? '0 :
                          pdoc_pkg::SA_HI_TBL[color[7:0]];
      s1_side_r.x      <= in_r.pos_x;
      s1_side_r.y      <= in_r.pos_y;
    end
  end

  // blend b over the first result
  pdoc_pkg::rgba_t mid_pix;

  pdoc_over_unit u_over_b (
    .clk    (clk),
    .en     (adv),
    .i_dest (s1_dest_r),
    .i_src  (s1_src_r),
    .i_sa   (s1_sa_r),
    .o_pix  (mid_pix)
  );

  side1_t side1_r [LAT];
  logic   vld1_r  [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld1_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld1_r[0] <= v1_r;
      for (int k = 1; k < LAT; k++) begin
        vld1_r[k] <= vld1_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1_r[0] <= s1_side_r;
      for (int k = 1; k < LAT; k++) begin
        side1_r[k] <= side1_r[k-1];
      end
    end
  end

  // palette blend; zero palette opacity passes the pixel through
  pdoc_pkg::rgba_t fin_pix;
  side1_t          s_mid;

  assign s_mid = side1_r[LAT-1];

  pdoc_over_unit u_over_pal (
    .clk    (clk),
    .en     (adv),
    .i_dest (mid_pix),
    .i_src  (s_mid.pal),
    .i_sa   (s_mid.pal_sa),
    .o_pix  (fin_pix)
  );

  side2_t side2_r [LAT];
  logic   vld2_r  [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld2_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld2_r[0] <= vld1_r[LAT-1];
      for (int k = 1; k < LAT; k++) begin
        vld2_r[k] <= vld2_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r[0].cls <= s_mid.cls;
      side2_r[0].x   <= s_mid.x;
      side2_r[0].y   <= s_mid.y;
      for (int k = 1; k < LAT; k++) begin
        side2_r[k] <= side2_r[k-1];
      end
    end
  end

  // the blend unit's last stage is the output register
  assign out_valid              = vld2_r[LAT-1];
  assign out_data.overlay_red   = fin_pix.red;
  assign out_data.overlay_green = fin_pix.green;
  assign out_data.overlay_blue  = fin_pix.blue;
  assign out_data.overlay_alpha = fin_pix.alpha;
  assign out_data.diff_class    = side2_r[LAT-1].cls;
  assign out_data.out_x         = side2_r[LAT-1].x;
  assign out_data.out_y         = side2_r[LAT-1].y;

endmodule

`default_nettype wire

[dv/tb_pixel_diff_overlay_compositor_core.sv]
// Self-checking testbench for pixel_diff_overlay_compositor_core: directed table plus
// random pixel words under varied idle/stall phases, checked by a fixed-point predictor.
// Depends on pdoc_pkg and the core RTL.
`default_nettype none

module tb_pixel_diff_overlay_compositor_core;

  localparam int LAT = 2 + 2 * pdoc_pkg::OVER_LAT;
  localparam longint unsigned ONE = 64'd1 << pdoc_pkg::FRAC;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  pdoc_pkg::pix_in_t  in_data;
  logic               out_valid;
  logic               out_stall;
  pdoc_pkg::pix_out_t out_data;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_wdata;

  pixel_diff_overlay_compositor_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  pdoc_pkg::rgba_t    palette [3];
  pdoc_pkg::pix_out_t pending_pix [$];
  int errors;
  int send_idle_pct;
  int stall_pct;

  typedef struct {
    pdoc_pkg::pix_in_t  px;
    logic               has_exp;
    pdoc_pkg::pix_out_t exp_px;
  } dir_row_t;
  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic longint unsigned sat8(longint unsigned v);
    return (v > 255) ? 64'd255 : v;
  endfunction

  // Porter-Duff over with the source alpha byte divided by div_k (opacity 255/div_k)
  function automatic void apply_over(inout longint unsigned p[4], input pdoc_pkg::rgba_t s,
                                     input longint unsigned div_k);
    longint unsigned sa, da, t, oa, sw, dw;
    sa = rdiv(longint'(s.alpha) * ONE, div_k);
    if (sa == 0) return;
    if (sa > ONE) sa = ONE;
    da = rdiv(p[3] * ONE, 255);
    t  = rdiv(da * (ONE - sa), ONE);
    oa = sa + t;
    sw = rdiv(sa * ONE, oa);
    dw = rdiv(t * ONE, oa);
    p[0] = sat8((longint'(s.red) * sw + p[0] * dw + ONE / 2) >> pdoc_pkg::FRAC);
    p[1] = sat8((longint'(s.green) * sw + p[1] * dw + ONE / 2) >> pdoc_pkg::FRAC);
    p[2] = sat8((longint'(s.blue) * sw + p[2] * dw + ONE / 2) >> pdoc_pkg::FRAC);
    p[3] = sat8((oa * 255 + ONE / 2) >> pdoc_pkg::FRAC);
  endfunction

  function automatic pdoc_pkg::pix_out_t composite_pixel(pdoc_pkg::pix_in_t w);
    longint unsigned p[4];
    pdoc_pkg::rgba_t a, b;
    pdoc_pkg::pix_out_t r;
    pdoc_pkg::diff_class_t c;
    p = '{0, 0, 0, 0};
    a = {w.a_red, w.a_green, w.a_blue, w.a_alpha};
    b = {w.b_red, w.b_green, w.b_blue, w.b_alpha};
    c = pdoc_pkg::CLS_NONE;
    apply_over(p, a, pdoc_pkg::LO_DIV);
    apply_over(p, b, pdoc_pkg::LO_DIV);
    if (!w.masked && a != b && !(a.alpha == 0 && b.alpha == 0)) begin
      if (a.alpha == 0) c = pdoc_pkg::CLS_ADD;
      else if (b.alpha == 0) c = pdoc_pkg::CLS_DEL;
      else c = pdoc_pkg::CLS_MOD;
      apply_over(p, palette[c == pdoc_pkg::CLS_ADD ? pdoc_pkg::REG_ADD_COLOR :
                            c == pdoc_pkg::CLS_DEL ? pdoc_pkg::REG_DEL_COLOR :
                                                     pdoc_pkg::REG_MOD_COLOR],
                 pdoc_pkg::HI_DIV);
    end
    r.overlay_red = p[0][7:0];
    r.overlay_green = p[1][7:0];
    r.overlay_blue = p[2][7:0];
    r.overlay_alpha = p[3][7:0];
    r.diff_class = c;
    r.out_x = w.pos_x;
    r.out_y = w.pos_y;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h want %0h @%0t", what, got, want, $time);
    errors++;
  endtask

  // output side: stall generation and checking
  always @(posedge clk) begin
    pdoc_pkg::pix_out_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_pix.size() == 0) begin
          report_mismatch("unexpected word", out_data, 0);
        end else begin
          e = pending_pix.pop_front();
          if (out_data.overlay_red != e.overlay_red)
            report_mismatch("red", out_data.overlay_red, e.overlay_red);
          if (out_data.overlay_green != e.overlay_green)
            report_mismatch("green", out_data.overlay_green, e.overlay_green);
          if (out_data.overlay_blue != e.overlay_blue)
            report_mismatch("blue", out_data.overlay_blue, e.overlay_blue);
          if (out_data.overlay_alpha != e.overlay_alpha)
            report_mismatch("alpha", out_data.overlay_alpha, e.overlay_alpha);
          if (out_data.diff_class != e.diff_class)
            report_mismatch("class", out_data.diff_class, e.diff_class);
          if (out_data.out_x != e.out_x) report_mismatch("x", out_data.out_x, e.out_x);
          if (out_data.out_y != e.out_y) report_mismatch("y", out_data.out_y, e.out_y);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(pdoc_pkg::pix_in_t w, bit has_exp, pdoc_pkg::pix_out_t exp_px);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (has_exp && composite_pixel(w) != exp_px)
      report_mismatch("table row", exp_px, composite_pixel(w));
    pending_pix.push_back(composite_pixel(w));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_palette(pdoc_pkg::cfg_reg_t idx, pdoc_pkg::rgba_t c);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    palette[idx] = c;
  endtask

  function automatic pdoc_pkg::pix_in_t rand_pixel();
    pdoc_pkg::pix_in_t w;
    logic [95:0] bits;
    int k;
    bits = {$urandom, $urandom, $urandom};
    w = bits[$bits(pdoc_pkg::pix_in_t)-1:0];
    k = $urandom_range(9);
    // bias toward the classification corners
    if (k == 0) w.a_alpha = 8'd0;
    if (k == 1) w.b_alpha = 8'd0;
    if (k == 2) {w.b_red, w.b_green, w.b_blue, w.b_alpha} =
                {w.a_red, w.a_green, w.a_blue, w.a_alpha};
    if (k == 3) begin w.a_alpha = 8'd0; w.b_alpha = 8'd0; end
    if (k == 4) w.a_alpha = 8'hff;
    w.masked = ($urandom_range(7) == 0);
    return w;
  endfunction

  function automatic pdoc_pkg::pix_in_t mk(logic [31:0] a, logic [31:0] b, logic m,
                                           logic [11:0] x, logic [11:0] y);
    pdoc_pkg::pix_in_t w;
    w = {a, b, m, x, y};
    return w;
  endfunction

  function automatic pdoc_pkg::pix_out_t mko(logic [31:0] o, pdoc_pkg::diff_class_t c,
                                             logic [11:0] x, logic [11:0] y);
    pdoc_pkg::pix_out_t r;
    r = {o, c, x, y};
    return r;
  endfunction

  initial begin
    int ph;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = pdoc_pkg::REG_ADD_COLOR;
    cfg_wdata = '0;
    out_stall = 1'b0;
    errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    foreach (palette[i]) palette[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, palette still at reset (alpha zero: class only)
    dir_rows.push_back('{mk(0, 0, 0, 0, 0), 1, mko(0, pdoc_pkg::CLS_NONE, 0, 0)});
    dir_rows.push_back('{mk(0, 0, 0, 12'hfff, 12'hfff), 1,
                         mko(0, pdoc_pkg::CLS_NONE, 12'hfff, 12'hfff)});
    dir_rows.push_back('{mk(0, 32'h000000ff, 0, 1, 2), 0, '0});
    dir_rows.push_back('{mk(32'h000000ff, 0, 0, 3, 4), 0, '0});
    dir_rows.push_back('{mk(32'hffffffff, 32'hffffffff, 0, 5, 6), 0, '0});
    dir_rows.push_back('{mk(32'hffffffff, 32'h000000ff, 0, 7, 8), 0, '0});
    dir_rows.push_back('{mk(32'hffffffff, 32'h000000ff, 1, 9, 10), 0, '0});
    dir_rows.push_back('{mk(32'h12345600, 32'h65432100, 0, 11, 12), 1,
                         mko(0, pdoc_pkg::CLS_NONE, 11, 12)});
    dir_rows.push_back('{mk(32'haa55aa01, 32'h55aa5501, 0, 12'h800, 12'h001), 0, '0});
    foreach (dir_rows[i]) send_word(dir_rows[i].px, dir_rows[i].has_exp, dir_rows[i].exp_px);
    drain();

    write_palette(pdoc_pkg::REG_ADD_COLOR, 32'h00ff00ff);
    write_palette(pdoc_pkg::REG_DEL_COLOR, 32'hff0000ff);
    write_palette(pdoc_pkg::REG_MOD_COLOR, 32'hffff0080);
    foreach (dir_rows[i]) send_word(dir_rows[i].px, 0, '0);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      if (ph == 4) begin
        write_palette(pdoc_pkg::REG_ADD_COLOR, 32'hffffffff);
        write_palette(pdoc_pkg::REG_DEL_COLOR, 32'h00000000);
        write_palette(pdoc_pkg::REG_MOD_COLOR, 32'h00000001);
      end else if (ph > 0) begin
        write_palette(pdoc_pkg::REG_ADD_COLOR, $urandom);
        write_palette(pdoc_pkg::REG_DEL_COLOR, $urandom);
        write_palette(pdoc_pkg::REG_MOD_COLOR, $urandom);
      end
      repeat (170) send_word(rand_pixel(), 0, '0);
      drain();
    end

    stall_pct = 0;
    if (errors == 0)
      $display("tb_pixel_diff_overlay_compositor_core: PASS");
    else
      $display("tb_pixel_diff_overlay_compositor_core: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_pixel_diff_overlay_compositor_core: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
